FILE: rtl/drsq_pkg.sv
// Shared types and constants for the dual range sensor qualifier.
`default_nettype none

package drsq_pkg;

  localparam int unsigned NOW_BITS    = 32;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MM_BITS     = 14;
  localparam int unsigned PERIOD_BITS = 16;
  localparam int unsigned THR_BITS    = 13;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned CFG_ADDR_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [MM_BITS-1:0] NO_TARGET_CODE   = 14'd8190;
  localparam logic [MM_BITS-1:0] SENSOR_DOWN_CODE = 14'd9999;

  localparam logic [PERIOD_BITS-1:0] RETRY_PERIOD_RST  = 16'd5000;
  localparam logic [PERIOD_BITS-1:0] STALE_TIMEOUT_RST = 16'd1000;
  localparam logic [THR_BITS-1:0]    NEAR_THR_RST      = 13'd200;
  localparam logic [THR_BITS-1:0]    CLEAR_THR_RST     = 13'd300;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_RETRY_PERIOD    = 2'd0,
    REG_STALE_TIMEOUT   = 2'd1,
    REG_NEAR_THRESHOLD  = 2'd2,
    REG_CLEAR_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] retry_period;
    logic [PERIOD_BITS-1:0] stale_timeout;
    logic [THR_BITS-1:0]    near_thr;
    logic [THR_BITS-1:0]    clear_thr;
  } cfg_t;

  typedef struct packed {
    logic               due;
    logic               up;
    logic [MM_BITS-1:0] mm;
  } side_status_t;

endpackage

`default_nettype wire

FILE: rtl/drsq_cfg_regs.sv
// Configuration register bank of the dual range sensor qualifier.
`default_nettype none

module drsq_cfg_regs
  import drsq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                          cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_period  <= RETRY_PERIOD_RST;
      cfg_r.stale_timeout <= STALE_TIMEOUT_RST;
      cfg_r.near_thr      <= NEAR_THR_RST;
      cfg_r.clear_thr     <= CLEAR_THR_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_addr))
        REG_RETRY_PERIOD:    cfg_r.retry_period  <= cfg_data;
        REG_STALE_TIMEOUT:   cfg_r.stale_timeout <= cfg_data;
        REG_NEAR_THRESHOLD:  cfg_r.near_thr      <= cfg_data[THR_BITS-1:0];
        REG_CLEAR_THRESHOLD: cfg_r.clear_thr     <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/drsq_side.sv
// Per-side state and update logic: bring-up, sample clamp and staleness.
`default_nettype none

module drsq_side
  import drsq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   advance,
  input  wire logic                   action,
  input  wire logic                   fire,
  input  wire logic [TIME_BITS-1:0]   now,
  input  wire logic                   ready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   begin_ok,
  output side_status_t                status
);

  logic                 up_r, up_nxt;
  logic [MM_BITS-1:0]   mm_r, mm_nxt;
  logic [TIME_BITS-1:0] stime_r, stime_nxt;
  logic [TIME_BITS-1:0] rtime_r, rtime_nxt;

  logic                 up_b;
  logic [MM_BITS-1:0]   mm_b;
  logic [TIME_BITS-1:0] stime_b;
  logic [TIME_BITS-1:0] retry_elapsed;
  logic [TIME_BITS-1:0] stale_elapsed;
  logic [MM_BITS-1:0]   clamped;

  assign retry_elapsed = now - rtime_r;
  assign status.due    = !up_r &&
                         (retry_elapsed >= TIME_BITS'(cfg.retry_period));

  always_comb begin
    if (fire) begin
      up_b    = begin_ok;
      mm_b    = begin_ok ? NO_TARGET_CODE : SENSOR_DOWN_CODE;
      stime_b = now;
    end else begin
      up_b    = up_r;
      mm_b    = mm_r;
      stime_b = stime_r;
    end
  end

  assign stale_elapsed = now - stime_b;
  assign clamped = (sample >= SAMPLE_BITS'(NO_TARGET_CODE)) ? NO_TARGET_CODE
                                                           : MM_BITS'(sample);

  always_comb begin
    up_nxt    = up_b;
    mm_nxt    = mm_b;
    stime_nxt = stime_b;
    rtime_nxt = fire ? now : rtime_r;
    if (!action && up_b) begin
      if (ready) begin
        mm_nxt    = clamped;
        stime_nxt = now;
      end else if (stale_elapsed >= TIME_BITS'(cfg.stale_timeout)) begin
        up_nxt    = 1'b0;
        mm_nxt    = SENSOR_DOWN_CODE;
        rtime_nxt = now;
      end
    end
  end

  assign status.up = up_nxt;
  assign status.mm = mm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r    <= 1'b0;
      mm_r    <= SENSOR_DOWN_CODE;
      stime_r <= '0;
      rtime_r <= '0;
    end else if (advance) begin
      up_r    <= up_nxt;
      mm_r    <= mm_nxt;
      stime_r <= stime_nxt;
      rtime_r <= rtime_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dual_range_sensor_qualifier.sv
// Top level of the dual range sensor qualifier.
// Each input transaction on in_* is one update tick (in_tuser = 0) or a forced
// rescan (in_tuser = 1) with the current time, both ready flags and samples
// and the bring-up outcome of both sides. Every input transaction yields
// exactly one result transaction on out_*, in order.
// The item is captured in an input register; once the output register is free
// or being drained, the side state, obstacle flag and bring-up counter update
// in one combinational pass and the result is loaded into the output register,
// which drives out_tvalid. One item is accepted every cycle while the output
// is drained.
// When the receiver holds out_tready low the output register holds its
// result, the input register holds one further item and in_tready drops.
// Configuration writes on cfg_* are always accepted (cfg_ready is high); the user
// must make them only while no item is in flight, which the block does not enforce.
// Synchronous reset (rst_n low) empties both registers, marks both sides
// unavailable (9999), clears the obstacle flag and the bring-up counter and
// loads the default periods and thresholds.
`default_nettype none

module dual_range_sensor_qualifier
  import drsq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  // input channel
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // now_ms[31:0], left_ready[32], left_sample[48:33], right_ready[49],
  // right_sample[65:50], left_begin_ok[66], right_begin_ok[67], zero[71:68]
  input  wire logic [71:0]              in_tdata,
  // action[0]
  input  wire logic                     in_tuser,
  // result channel
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // left_distance[13:0], right_distance[27:14], left_valid[28],
  // right_valid[29], obstacle[30], bringup_fired[31], bringup_total[63:32]
  output logic [63:0]                   out_tdata
);

  cfg_t cfg;

  logic        in_valid_r;
  logic [67:0] in_data_r;
  logic        in_action_r;
  logic        advance;

  logic        out_valid_r;
  logic [63:0] out_data_r;

  logic                  obstacle_r, obstacle_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic                   fire;
  logic [TIME_BITS-1:0]   now;
  side_status_t           left_st, right_st;
  logic                   any_close, all_clear;

  drsq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r   <= in_tdata[67:0];
      in_action_r <= in_tuser;
    end
  end

  assign now  = TIME_BITS'(in_data_r[NOW_BITS-1:0]);
  assign fire = in_action_r || left_st.due || right_st.due;

  drsq_side #(.TIME_BITS(TIME_BITS)) u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .advance  (advance),
    .action   (in_action_r),
    .fire     (fire),
    .now      (now),
    .ready    (in_data_r[32]),
    .sample   (in_data_r[48:33]),
    .begin_ok (in_data_r[66]),
    .status   (left_st)
  );

  drsq_side #(.TIME_BITS(TIME_BITS)) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .advance  (advance),
    .action   (in_action_r),
    .fire     (fire),
    .now      (now),
    .ready    (in_data_r[49]),
    .sample   (in_data_r[65:50]),
    .begin_ok (in_data_r[67]),
    .status   (right_st)
  );

  assign any_close = (left_st.up  && (left_st.mm  < MM_BITS'(cfg.near_thr))) ||
                     (right_st.up && (right_st.mm < MM_BITS'(cfg.near_thr)));
  assign all_clear = (!left_st.up  || (left_st.mm  > MM_BITS'(cfg.clear_thr))) &&
                     (!right_st.up || (right_st.mm > MM_BITS'(cfg.clear_thr)));

  always_comb begin
    obstacle_nxt = obstacle_r;
    if (!in_action_r) begin
      if (any_close) begin
        obstacle_nxt = 1'b1;
      end else if (all_clear) begin
        obstacle_nxt = 1'b0;
      end
    end
  end

  assign count_nxt = fire ? count_r + COUNT_BITS'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obstacle_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        obstacle_r <= obstacle_nxt;
        count_r    <= count_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {count_nxt, fire, obstacle_nxt, right_st.up, left_st.up,
                     right_st.mm, left_st.mm};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && fire |=> count_r == $past(count_r) + COUNT_BITS'(1))
    else $error("bring-up counter did not advance on a bring-up pass");

  a_left_down_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[28] |-> out_data_r[13:0] == SENSOR_DOWN_CODE)
    else $error("left side down without unavailable code");

  a_right_up_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[29] |-> out_data_r[27:14] <= NO_TARGET_CODE)
    else $error("right side up with distance beyond out-of-range code");

  a_fired_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !fire |=> count_r == $past(count_r))
    else $error("bring-up counter moved without a bring-up pass");
`endif

endmodule

`default_nettype wire
